/* src/refcounted_page_allocator_unit_defines.svh */
// Assertion macros used by the page allocator top level.
`ifndef REFCOUNTED_PAGE_ALLOCATOR_UNIT_DEFINES_SVH
`define REFCOUNTED_PAGE_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define RPA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled in reset.
`define RPA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/rpa_pkg.sv */
// Shared types, codes and defaults for the page allocator.
`default_nettype none
package rpa_pkg;

	localparam int ADDR_W = 34;
	localparam int CNT_W  = 16;

	localparam int NUM_PAGES_DEF  = 32768;
	localparam int PAGE_BYTES_DEF = 4096;

	localparam logic [ADDR_W-1:0] FREE_FLOOR_RST = 34'h080000000;
	localparam logic [ADDR_W-1:0] BASE_ADDR_RST  = 34'h080000000;

	// operation codes
	localparam logic [1:0] OP_ALLOC      = 2'd0;
	localparam logic [1:0] OP_FREE       = 2'd1;
	localparam logic [1:0] OP_ADD_REF    = 2'd2;
	localparam logic [1:0] OP_READ_COUNT = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_OOM      = 2'd1;
	localparam logic [1:0] ST_BAD_ADDR = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	// configuration register indexes
	localparam logic REG_FREE_FLOOR = 1'b0;
	localparam logic REG_BASE_ADDR  = 1'b1;

	typedef struct packed {
		logic in_region;
		logic aligned;
		logic above_floor;
	} rpa_chk_t;

endpackage
`default_nettype wire

/* src/rpa_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module rpa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32768
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

/* src/rpa_addr_check.sv */
// Address decode: region, alignment and floor checks plus page index.
`default_nettype none
module rpa_addr_check #(
	parameter int NUM_PAGES  = rpa_pkg::NUM_PAGES_DEF,
	parameter int PAGE_BYTES = rpa_pkg::PAGE_BYTES_DEF
) (
	input  wire logic [rpa_pkg::ADDR_W-1:0]    page_addr,
	input  wire logic [rpa_pkg::ADDR_W-1:0]    base_address,
	input  wire logic [rpa_pkg::ADDR_W-1:0]    free_floor,
	output rpa_pkg::rpa_chk_t                  chk,
	output logic      [$clog2(NUM_PAGES)-1:0]  idx
);
	import rpa_pkg::*;

	localparam int IDX_W      = $clog2(NUM_PAGES);
	localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

	logic [ADDR_W-1:0] off;
	logic [ADDR_W-1:0] pgn;

	assign off = page_addr - base_address;
	assign pgn = off >> PAGE_SHIFT;

	// top of region never wraps: offset in pages against the page count
	assign chk.in_region   = (page_addr >= base_address) && (pgn < ADDR_W'(NUM_PAGES));
	assign chk.aligned     = (page_addr[PAGE_SHIFT-1:0] == '0);
	assign chk.above_floor = (page_addr >= free_floor);
	assign idx             = pgn[IDX_W-1:0];

endmodule
`default_nettype wire

/* src/refcounted_page_allocator_unit.sv */
// Top level of the reference-counted page allocator.
//
// Command channel: an operation (op, page_addr) is taken at a rising edge with
// start high and busy low. Exactly one result (status, alloc_addr, ref_count,
// page_released) follows, shown for one cycle with done high; it cannot be
// held off by the receiver.
// Sequence: an alloc that finds the stack non-empty goes from the accepting
// edge to the pop state (stack read), then the execute state (count read);
// other items go straight to the execute state, from which done is
// registered; busy stays high until done. A new item may be taken in the
// cycle that done is shown. Reset: counts are cleared by a pass over the
// count RAM, one entry a cycle; busy is high throughout and start is
// ignored. The free stack starts empty; software fills it by issuing frees.
// Configuration: cfg_wen, cfg_index, cfg_data write free_floor (index 0) or
// base_address (index 1) at once; the user must do so only while the block
// is idle, which the block itself does not enforce.
`default_nettype none
`include "refcounted_page_allocator_unit_defines.svh"
module refcounted_page_allocator_unit #(
	parameter int NUM_PAGES  = rpa_pkg::NUM_PAGES_DEF,
	parameter int PAGE_BYTES = rpa_pkg::PAGE_BYTES_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_wen,
	input  wire logic                        cfg_index,
	input  wire logic [rpa_pkg::ADDR_W-1:0]  cfg_data,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic [1:0]                  op,
	input  wire logic [rpa_pkg::ADDR_W-1:0]  page_addr,
	output logic                             done,
	output logic      [1:0]                  status,
	output logic      [rpa_pkg::ADDR_W-1:0]  alloc_addr,
	output logic      [rpa_pkg::CNT_W-1:0]   ref_count,
	output logic                             page_released
);
	import rpa_pkg::*;

	localparam int IDX_W      = $clog2(NUM_PAGES);
	localparam int DEP_W      = $clog2(NUM_PAGES + 1);
	localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

	localparam logic [1:0] S_CLEAR = 2'd0;
	localparam logic [1:0] S_IDLE  = 2'd1;
	localparam logic [1:0] S_POP   = 2'd2;
	localparam logic [1:0] S_EXEC  = 2'd3;

	logic [1:0]        state_q;
	logic [IDX_W-1:0]  clr_q;
	logic [DEP_W-1:0]  depth_q;
	logic [DEP_W-1:0]  depth_d;
	logic [DEP_W-1:0]  dep_m1;
	logic [ADDR_W-1:0] free_floor_q;
	logic [ADDR_W-1:0] base_addr_q;

	logic              accept;
	rpa_chk_t          chk;
	logic [IDX_W-1:0]  chk_idx;

	logic [1:0]        op_s1;
	rpa_chk_t          chk_s1;
	logic              empty_s1;
	logic [IDX_W-1:0]  idx_s1;

	logic              cnt_we;
	logic [IDX_W-1:0]  cnt_waddr;
	logic [CNT_W-1:0]  cnt_wdata;
	logic [IDX_W-1:0]  cnt_raddr;
	logic [CNT_W-1:0]  cnt_rd;
	logic [CNT_W-1:0]  cnt_inc;

	logic              stk_we;
	logic [IDX_W-1:0]  stk_rd;

	logic              x_cnt_we;
	logic [CNT_W-1:0]  x_cnt_wdata;
	logic              x_stk_we;
	logic [1:0]        r_status;
	logic [ADDR_W-1:0] r_addr;
	logic [CNT_W-1:0]  r_cnt;
	logic              r_rel;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign dep_m1 = depth_q - DEP_W'(1);

	rpa_addr_check #(
		.NUM_PAGES  (NUM_PAGES),
		.PAGE_BYTES (PAGE_BYTES)
	) u_chk (
		.page_addr    (page_addr),
		.base_address (base_addr_q),
		.free_floor   (free_floor_q),
		.chk          (chk),
		.idx          (chk_idx)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_floor_q <= FREE_FLOOR_RST;
			base_addr_q  <= BASE_ADDR_RST;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_FREE_FLOOR: free_floor_q <= cfg_data;
				REG_BASE_ADDR:  base_addr_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// count RAM: clearing pass, otherwise execute-stage write
	assign cnt_we    = (state_q == S_CLEAR) || ((state_q == S_EXEC) && x_cnt_we);
	assign cnt_waddr = (state_q == S_CLEAR) ? clr_q : idx_s1;
	assign cnt_wdata = (state_q == S_CLEAR) ? '0 : x_cnt_wdata;
	assign cnt_raddr = (state_q == S_POP) ? stk_rd : chk_idx;
	assign cnt_inc   = (cnt_rd == '1) ? cnt_rd : cnt_rd + CNT_W'(1);

	rpa_ram #(
		.WIDTH (CNT_W),
		.DEPTH (NUM_PAGES)
	) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.raddr (cnt_raddr),
		.rdata (cnt_rd)
	);

	assign stk_we = (state_q == S_EXEC) && x_stk_we;

	// stack read always looks at the top entry
	rpa_ram #(
		.WIDTH (IDX_W),
		.DEPTH (NUM_PAGES)
	) u_stk_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (depth_q[IDX_W-1:0]),
		.wdata (idx_s1),
		.raddr (dep_m1[IDX_W-1:0]),
		.rdata (stk_rd)
	);

	// execute stage: count read data is valid here
	always_comb begin
		x_cnt_we    = 1'b0;
		x_cnt_wdata = '0;
		x_stk_we    = 1'b0;
		depth_d     = depth_q;
		r_status    = ST_OK;
		r_addr      = '0;
		r_cnt       = '0;
		r_rel       = 1'b0;
		case (op_s1) inside
			OP_ALLOC: begin
				if (empty_s1) begin
					r_status = ST_OOM;
				end else begin
					x_cnt_we    = 1'b1;
					x_cnt_wdata = cnt_inc;
					depth_d     = dep_m1;
					r_addr      = base_addr_q + ADDR_W'({idx_s1, {PAGE_SHIFT{1'b0}}});
					r_cnt       = cnt_inc;
				end
			end
			OP_FREE: begin
				if (!chk_s1.aligned || !chk_s1.above_floor || !chk_s1.in_region) begin
					r_status = ST_BAD_ADDR;
				end else if (cnt_rd > CNT_W'(1)) begin
					x_cnt_we    = 1'b1;
					x_cnt_wdata = cnt_rd - CNT_W'(1);
					r_cnt       = cnt_rd - CNT_W'(1);
				end else if (depth_q == DEP_W'(NUM_PAGES)) begin
					r_status = ST_FULL;
				end else begin
					x_cnt_we = 1'b1;
					x_stk_we = 1'b1;
					depth_d  = depth_q + DEP_W'(1);
					r_rel    = 1'b1;
				end
			end
			OP_ADD_REF, OP_READ_COUNT: begin
				if (!chk_s1.in_region) begin
					r_status = ST_BAD_ADDR;
				end else if (op_s1 == OP_ADD_REF) begin
					x_cnt_we    = 1'b1;
					x_cnt_wdata = cnt_inc;
					r_cnt       = cnt_inc;
				end else begin
					r_cnt = cnt_rd;
				end
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			depth_q <= '0;
			done    <= 1'b0;
		end else begin
			done <= (state_q == S_EXEC);
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + IDX_W'(1);
					if (clr_q == IDX_W'(NUM_PAGES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= ((op == OP_ALLOC) && (depth_q != '0)) ? S_POP : S_EXEC;
					end
				end
				S_POP: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					depth_q <= depth_d;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// item registers and result registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= op;
			chk_s1   <= chk;
			empty_s1 <= (depth_q == '0);
			idx_s1   <= chk_idx;
		end else if (state_q == S_POP) begin
			idx_s1 <= stk_rd;
		end
		if (state_q == S_EXEC) begin
			status        <= r_status;
			alloc_addr    <= r_addr;
			ref_count     <= r_cnt;
			page_released <= r_rel;
		end
	end

	`RPA_ASSERT_NEXT(a_done_single, done, !done, "result strobe held for more than one cycle")
	`RPA_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted transaction did not occupy the block")
	`RPA_ASSERT_NEXT(a_exec_done, state_q == S_EXEC, done, "execute stage gave no result")
	`RPA_ASSERT_NOW(a_depth_max, 1'b1, depth_q <= DEP_W'(NUM_PAGES), "free stack depth overrun")
	`RPA_ASSERT_NOW(a_rel_ok, done && page_released, status == ST_OK, "release with bad status")

endmodule
`default_nettype wire
